// ===== rtl/sfk_pkg.sv =====
// Shared types, constants and the rotation micro-op table for the skeleton
// forward kinematics core. No dependencies.
package sfk_pkg;

    localparam int MAX_JOINTS  = 256;
    localparam int STORE_DEPTH = MAX_JOINTS * 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int JOINT_LIM   = (MAX_JOINTS < 256) ? MAX_JOINTS : 256;

    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    typedef enum logic [1:0] {
        OP_ROT,
        OP_SCL,
        OP_PAR
    } op_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_ROT_WAIT,
        S_SCL,
        S_SCL_WAIT,
        S_PAR,
        S_PAR_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     valid;
        op_kind_t kind;
        logic     first;
        logic     bias;
        logic     neg;
        logic     dbl;
        logic     last;
        logic [3:0] dst;
    } mac_ctl_t;

    typedef struct packed {
        mac_ctl_t   mac;
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] kk;
    } issue_t;

    typedef struct packed {
        logic        valid;
        op_kind_t    kind;
        logic [3:0]  dst;
        logic [31:0] data;
    } wb_t;

    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic       neg;
        logic       bias;
    } rot_op_t;

    // Two accumulate steps per rotation element; the first of r00, r11 and
    // r22 starts from one in Q4.28.
    function automatic rot_op_t rot_op(input logic [4:0] step);
        rot_op_t op;
        op = '{ia: Q_W, ib: Q_W, neg: 1'b0, bias: 1'b0};
        case (step)
            5'd0:  op = '{ia: Q_Y, ib: Q_Y, neg: 1'b1, bias: 1'b1};
            5'd1:  op = '{ia: Q_Z, ib: Q_Z, neg: 1'b1, bias: 1'b0};
            5'd2:  op = '{ia: Q_X, ib: Q_Y, neg: 1'b0, bias: 1'b0};
            5'd3:  op = '{ia: Q_W, ib: Q_Z, neg: 1'b1, bias: 1'b0};
            5'd4:  op = '{ia: Q_X, ib: Q_Z, neg: 1'b0, bias: 1'b0};
            5'd5:  op = '{ia: Q_W, ib: Q_Y, neg: 1'b0, bias: 1'b0};
            5'd6:  op = '{ia: Q_X, ib: Q_Y, neg: 1'b0, bias: 1'b0};
            5'd7:  op = '{ia: Q_W, ib: Q_Z, neg: 1'b0, bias: 1'b0};
            5'd8:  op = '{ia: Q_X, ib: Q_X, neg: 1'b1, bias: 1'b1};
            5'd9:  op = '{ia: Q_Z, ib: Q_Z, neg: 1'b1, bias: 1'b0};
            5'd10: op = '{ia: Q_Y, ib: Q_Z, neg: 1'b0, bias: 1'b0};
            5'd11: op = '{ia: Q_W, ib: Q_X, neg: 1'b1, bias: 1'b0};
            5'd12: op = '{ia: Q_X, ib: Q_Z, neg: 1'b0, bias: 1'b0};
            5'd13: op = '{ia: Q_W, ib: Q_Y, neg: 1'b1, bias: 1'b0};
            5'd14: op = '{ia: Q_Y, ib: Q_Z, neg: 1'b0, bias: 1'b0};
            5'd15: op = '{ia: Q_W, ib: Q_X, neg: 1'b0, bias: 1'b0};
            5'd16: op = '{ia: Q_X, ib: Q_X, neg: 1'b1, bias: 1'b1};
            5'd17: op = '{ia: Q_Y, ib: Q_Y, neg: 1'b1, bias: 1'b0};
            default: op = '{ia: Q_W, ib: Q_W, neg: 1'b0, bias: 1'b0};
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/skeleton_forward_kinematics_core.sv =====
// Top level of the skeleton forward kinematics core: sequencer, operand
// selection, matrix store and result rows. Depends on sfk_pkg, sfk_mac, sfk_ram.
//
// Each joint request is processed alone on one shared 32x32 multiplier: 18
// accumulate steps build the rotation, 9 apply the scale, and 64 form the
// parent product (a root joint is multiplied by the identity). After each of
// the three phases the sequencer waits for the multiplier pipeline to drain.
// The four rows then leave at the pace of m_ready, and the next request can
// be taken in the cycle after the last row. s_ready is high only while no
// joint is in work.
module skeleton_forward_kinematics_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    input  logic signed [31:0] s_scale_z,
    input  logic signed [8:0]  s_parent_index,
    input  logic               s_last_joint,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_joint_number,
    output logic [1:0]         m_row_number,
    output logic signed [31:0] m_elem_0,
    output logic signed [31:0] m_elem_1,
    output logic signed [31:0] m_elem_2,
    output logic signed [31:0] m_elem_3,
    output logic               m_final_row
);

    sfk_pkg::state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  row_reg, row_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  joint_reg;
    logic [7:0]  parent_reg;
    logic        use_par_reg;
    logic [8:0]  cnt_inc;

    logic signed [31:0] pos_reg   [3];
    logic signed [31:0] scale_reg [3];
    logic signed [15:0] quat_reg  [4];
    logic signed [31:0] rq_reg    [9];
    logic signed [31:0] loc_reg   [9];
    logic signed [31:0] res_reg   [16];

    sfk_pkg::issue_t  issue, s1_reg;
    sfk_pkg::rot_op_t rop;
    sfk_pkg::wb_t     wb;
    logic             mac_busy, drained, accept;
    logic signed [31:0] op_a, op_b, ram_rdata;
    logic [sfk_pkg::ADDR_W-1:0] raddr, waddr;
    logic [1:0] s1_r, s1_c, s1_col;
    logic [3:0] loc_idx;

    assign accept  = s_valid && s_ready;
    assign drained = !s1_reg.mac.valid && !mac_busy;
    assign cnt_inc = {1'b0, cnt_reg} + 9'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfk_pkg::S_IDLE:     if (s_valid) state_next = sfk_pkg::S_ROT;
            sfk_pkg::S_ROT:      if (step_reg == 6'd17) state_next = sfk_pkg::S_ROT_WAIT;
            sfk_pkg::S_ROT_WAIT: if (drained) state_next = sfk_pkg::S_SCL;
            sfk_pkg::S_SCL:      if (step_reg == 6'd8) state_next = sfk_pkg::S_SCL_WAIT;
            sfk_pkg::S_SCL_WAIT: if (drained) state_next = sfk_pkg::S_PAR;
            sfk_pkg::S_PAR:      if (step_reg == 6'd63) state_next = sfk_pkg::S_PAR_WAIT;
            sfk_pkg::S_PAR_WAIT: if (drained) state_next = sfk_pkg::S_OUT;
            sfk_pkg::S_OUT: begin
                if (m_ready && row_reg == 2'd3) state_next = sfk_pkg::S_IDLE;
            end
            default:             state_next = sfk_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == sfk_pkg::S_IDLE);
        m_valid   = (state_reg == sfk_pkg::S_OUT);
        step_next = step_reg;
        row_next  = row_reg;
        if (state_next != state_reg) begin
            step_next = '0;
        end else if (state_reg == sfk_pkg::S_ROT || state_reg == sfk_pkg::S_SCL
                     || state_reg == sfk_pkg::S_PAR) begin
            step_next = step_reg + 6'd1;
        end
        if (state_reg == sfk_pkg::S_OUT && m_ready) begin
            row_next = row_reg + 2'd1;
        end else if (state_reg != sfk_pkg::S_OUT) begin
            row_next = '0;
        end
        rop = sfk_pkg::rot_op(step_reg[4:0]);
        issue = '0;
        unique case (state_reg)
            sfk_pkg::S_ROT: begin
                issue.mac.valid = 1'b1;
                issue.mac.kind  = sfk_pkg::OP_ROT;
                issue.mac.first = !step_reg[0];
                issue.mac.last  = step_reg[0];
                issue.mac.bias  = rop.bias;
                issue.mac.neg   = rop.neg;
                issue.mac.dbl   = 1'b1;
                issue.mac.dst   = step_reg[4:1];
                issue.ia        = rop.ia;
                issue.ib        = rop.ib;
            end
            sfk_pkg::S_SCL: begin
                issue.mac.valid = 1'b1;
                issue.mac.kind  = sfk_pkg::OP_SCL;
                issue.mac.first = 1'b1;
                issue.mac.last  = 1'b1;
                issue.mac.dst   = step_reg[3:0];
            end
            sfk_pkg::S_PAR: begin
                issue.mac.valid = 1'b1;
                issue.mac.kind  = sfk_pkg::OP_PAR;
                issue.mac.first = (step_reg[1:0] == 2'd0);
                issue.mac.last  = (step_reg[1:0] == 2'd3);
                issue.mac.dst   = step_reg[5:2];
                issue.kk        = step_reg[1:0];
            end
            default: issue = '0;
        endcase
        raddr = sfk_pkg::ADDR_W'({parent_reg, step_reg[5:4], step_reg[1:0]});
        waddr = sfk_pkg::ADDR_W'({joint_reg, wb.dst});
        if (cnt_inc >= 9'(sfk_pkg::JOINT_LIM) || s_last_joint) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_inc[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfk_pkg::S_IDLE;
            step_reg  <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            s1_reg    <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            s1_reg    <= issue;
            if (accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            joint_reg    <= cnt_reg;
            parent_reg   <= s_parent_index[7:0];
            use_par_reg  <= !s_parent_index[8] && (s_parent_index[7:0] < cnt_reg);
            pos_reg[0]   <= s_pos_x;
            pos_reg[1]   <= s_pos_y;
            pos_reg[2]   <= s_pos_z;
            scale_reg[0] <= s_scale_x;
            scale_reg[1] <= s_scale_y;
            scale_reg[2] <= s_scale_z;
            quat_reg[0]  <= s_quat_w;
            quat_reg[1]  <= s_quat_x;
            quat_reg[2]  <= s_quat_y;
            quat_reg[3]  <= s_quat_z;
        end
        if (wb.valid) begin
            case (wb.kind)
                sfk_pkg::OP_ROT: rq_reg[wb.dst]  <= wb.data;
                sfk_pkg::OP_SCL: loc_reg[wb.dst] <= wb.data;
                default:         res_reg[wb.dst] <= wb.data;
            endcase
        end
    end

    always_comb begin
        s1_r    = s1_reg.mac.dst[3:2];
        s1_c    = s1_reg.mac.dst[1:0];
        s1_col  = 2'd0;
        case (s1_reg.mac.dst)
            4'd1, 4'd4, 4'd7: s1_col = 2'd1;
            4'd2, 4'd5, 4'd8: s1_col = 2'd2;
            default:          s1_col = 2'd0;
        endcase
        loc_idx = 4'({2'd0, s1_reg.kk} * 4'd3) + {2'd0, s1_c};
        case (s1_reg.mac.kind)
            sfk_pkg::OP_ROT: begin
                op_a = {{16{quat_reg[s1_reg.ia][15]}}, quat_reg[s1_reg.ia]};
                op_b = {{16{quat_reg[s1_reg.ib][15]}}, quat_reg[s1_reg.ib]};
            end
            sfk_pkg::OP_SCL: begin
                op_a = rq_reg[s1_reg.mac.dst];
                op_b = (s1_col == 2'd3) ? 32'sd0 : scale_reg[s1_col];
            end
            default: begin
                if (use_par_reg) begin
                    op_a = ram_rdata;
                end else begin
                    op_a = (s1_reg.kk == s1_r) ? 32'sd65536 : 32'sd0;
                end
                if (s1_reg.kk == 2'd3) begin
                    op_b = (s1_c == 2'd3) ? 32'sd65536 : 32'sd0;
                end else if (s1_c == 2'd3) begin
                    op_b = pos_reg[s1_reg.kk];
                end else begin
                    op_b = loc_reg[loc_idx];
                end
            end
        endcase
    end

    sfk_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (s1_reg.mac),
        .op_a    (op_a),
        .op_b    (op_b),
        .busy    (mac_busy),
        .wb      (wb)
    );

    sfk_ram #(
        .WIDTH (32),
        .DEPTH (sfk_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wb.valid && wb.kind == sfk_pkg::OP_PAR),
        .waddr (waddr),
        .wdata (wb.data),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign m_joint_number = joint_reg;
    assign m_row_number   = row_reg;
    assign m_elem_0       = res_reg[{row_reg, 2'd0}];
    assign m_elem_1       = res_reg[{row_reg, 2'd1}];
    assign m_elem_2       = res_reg[{row_reg, 2'd2}];
    assign m_elem_3       = res_reg[{row_reg, 2'd3}];
    assign m_final_row    = (row_reg == 2'd3);

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sfk_pkg::S_IDLE |-> !s1_reg.mac.valid && !mac_busy)
        else $error("multiplier pipeline busy while idle");

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb.valid && wb.kind == sfk_pkg::OP_PAR) |->
            (state_reg == sfk_pkg::S_PAR || state_reg == sfk_pkg::S_PAR_WAIT))
        else $error("matrix store written outside parent phase");

endmodule

// ===== rtl/sfk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sfk_mac.sv =====
// Shared 32x32 multiply-accumulate unit with rounding and saturation at
// write-back. Depends on sfk_pkg.
module sfk_mac (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfk_pkg::mac_ctl_t    ctl_in,
    input  logic signed [31:0]   op_a,
    input  logic signed [31:0]   op_b,
    output logic                 busy,
    output sfk_pkg::wb_t         wb
);

    localparam logic signed [67:0] ONE28 = 68'sd268435456;
    localparam logic signed [67:0] MAXV  = 68'sh7FFFFFFF;
    localparam logic signed [67:0] MINV  = -68'sh80000000;

    sfk_pkg::mac_ctl_t  ctl2_reg, ctl3_reg;
    logic signed [63:0] prod_reg;
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] term, rnd, shd;

    always_comb begin
        term = {{4{prod_reg[63]}}, prod_reg};
        if (ctl2_reg.dbl) begin
            term = term <<< 1;
        end
        if (ctl2_reg.neg) begin
            term = -term;
        end
        if (ctl2_reg.first) begin
            acc_next = (ctl2_reg.bias ? ONE28 : 68'sd0) + term;
        end else begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
        end
        prod_reg <= op_a * op_b;
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        if (ctl3_reg.kind == sfk_pkg::OP_ROT) begin
            rnd = acc_reg + 68'sd2048;
            shd = rnd >>> 12;
        end else begin
            rnd = acc_reg + 68'sd32768;
            shd = rnd >>> 16;
        end
        wb.valid = ctl3_reg.valid && ctl3_reg.last;
        wb.kind  = ctl3_reg.kind;
        wb.dst   = ctl3_reg.dst;
        if (shd > MAXV) begin
            wb.data = 32'h7FFFFFFF;
        end else if (shd < MINV) begin
            wb.data = 32'h80000000;
        end else begin
            wb.data = shd[31:0];
        end
    end

    assign busy = ctl2_reg.valid || ctl3_reg.valid;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for skeleton_forward_kinematics_core: joint requests in bursts,
// model-matrix rows predicted in fixed point and checked in order by a scoreboard class.
// Depends on the RTL top level and sfk_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [15:0] quat [4];
        logic signed [31:0] scale [3];
        logic signed [8:0]  parent;
        logic               last;
    } joint_req_t;

    typedef struct {
        logic [7:0]         joint;
        logic [1:0]         row;
        logic signed [31:0] elem [4];
        logic               fin;
    } matrix_row_t;

    class pose_scoreboard;
        logic signed [31:0] model_mats [sfk_pkg::MAX_JOINTS * 16];
        int unsigned        joint_cnt;
        matrix_row_t        rows_due [$];
        int                 errors;

        function new();
            joint_cnt = 0;
            errors    = 0;
        endfunction

        function logic signed [31:0] round_clip(logic signed [127:0] v, int s);
            logic signed [127:0] t;
            t = (v + (128'sd1 <<< (s - 1))) >>> s;
            if (t > 128'sd2147483647) return 32'sh7fffffff;
            if (t < -128'sd2147483648) return 32'sh80000000;
            return t[31:0];
        endfunction

        function void note_request(joint_req_t q);
            logic signed [63:0]  w, x, y, z, rq;
            logic signed [63:0]  rot [3][3];
            logic signed [31:0]  loc [16];
            logic signed [31:0]  res [16];
            logic signed [127:0] acc;
            logic signed [63:0]  one28;
            int unsigned         j;
            matrix_row_t         mr;
            one28 = 64'sd1 <<< 28;
            w = 64'(q.quat[0]); x = 64'(q.quat[1]); y = 64'(q.quat[2]); z = 64'(q.quat[3]);
            rot[0][0] = one28 - 64'sd2 * (y * y + z * z);
            rot[0][1] = 64'sd2 * (x * y - w * z);
            rot[0][2] = 64'sd2 * (x * z + w * y);
            rot[1][0] = 64'sd2 * (x * y + w * z);
            rot[1][1] = one28 - 64'sd2 * (x * x + z * z);
            rot[1][2] = 64'sd2 * (y * z - w * x);
            rot[2][0] = 64'sd2 * (x * z - w * y);
            rot[2][1] = 64'sd2 * (y * z + w * x);
            rot[2][2] = one28 - 64'sd2 * (x * x + y * y);
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    rq  = 64'(round_clip(128'(rot[r][c]), 12));
                    acc = 128'(rq) * 128'(q.scale[c]);
                    loc[r * 4 + c] = round_clip(acc, 16);
                end
                loc[r * 4 + 3] = q.pos[r];
            end
            loc[12] = 0; loc[13] = 0; loc[14] = 0; loc[15] = 32'sd65536;
            j = joint_cnt;
            if (q.parent >= 0 && int'(q.parent) < int'(j)) begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        acc = '0;
                        for (int k = 0; k < 4; k++) begin
                            acc = acc + 128'(model_mats[q.parent * 16 + r * 4 + k])
                                      * 128'(loc[k * 4 + c]);
                        end
                        res[r * 4 + c] = round_clip(acc, 16);
                    end
                end
            end else begin
                res = loc;
            end
            for (int i = 0; i < 16; i++) model_mats[j * 16 + i] = res[i];
            for (int r = 0; r < 4; r++) begin
                mr.joint = j[7:0];
                mr.row   = r[1:0];
                for (int c = 0; c < 4; c++) mr.elem[c] = res[r * 4 + c];
                mr.fin = (r == 3);
                rows_due = {rows_due, mr};
            end
            if (q.last) joint_cnt = 0;
            else joint_cnt = (j + 1 >= sfk_pkg::JOINT_LIM) ? 0 : j + 1;
        endfunction

        function void check_row(matrix_row_t got);
            matrix_row_t exp_row;
            if (rows_due.size() == 0) begin
                $error("unexpected row: joint %0d row %0d", got.joint, got.row);
                errors++;
                return;
            end
            exp_row = rows_due.pop_front();
            if (got.joint !== exp_row.joint) begin
                $error("joint_number: expected %0d, got %0d", exp_row.joint, got.joint);
                errors++;
            end
            if (got.row !== exp_row.row) begin
                $error("row_number: expected %0d, got %0d", exp_row.row, got.row);
                errors++;
            end
            for (int c = 0; c < 4; c++) begin
                if (got.elem[c] !== exp_row.elem[c]) begin
                    $error("elem_%0d: expected %0d, got %0d", c, exp_row.elem[c], got.elem[c]);
                    errors++;
                end
            end
            if (got.fin !== exp_row.fin) begin
                $error("final_row: expected %0d, got %0d", exp_row.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic signed [31:0] s_scale_x = '0, s_scale_y = '0, s_scale_z = '0;
    logic signed [8:0]  s_parent_index = '0;
    logic               s_last_joint = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_joint_number;
    logic [1:0]         m_row_number;
    logic signed [31:0] m_elem_0, m_elem_1, m_elem_2, m_elem_3;
    logic               m_final_row;

    pose_scoreboard sb = new();
    bit             stim_done = 1'b0;

    skeleton_forward_kinematics_core u_top (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic joint_req_t make_joint(logic signed [31:0] p, logic signed [15:0] qw,
                                              logic signed [15:0] qx, logic signed [31:0] s,
                                              logic signed [8:0] par, logic lst);
        joint_req_t t;
        t.pos   = '{p, -p, p >>> 1};
        t.quat  = '{qw, qx, -qx, qx >>> 2};
        t.scale = '{s, s, s};
        t.parent = par;
        t.last   = lst;
        return t;
    endfunction

    function automatic joint_req_t rand_joint(int j, bit lst);
        joint_req_t t;
        for (int i = 0; i < 3; i++) begin
            t.pos[i]   = ($urandom_range(0, 3) == 0) ? $urandom
                                                     : $signed($urandom_range(0, 2**22)) - 2**21;
            t.scale[i] = ($urandom_range(0, 4) == 0) ? $urandom
                                                     : 32'sd65536 + $urandom_range(0, 2**16) - 2**15;
        end
        for (int i = 0; i < 4; i++) begin
            t.quat[i] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        case ($urandom_range(0, 9))
            0:       t.parent = 9'($urandom);
            1:       t.parent = -9'sd1;
            2:       t.parent = 9'(j);
            default: t.parent = (j == 0) ? -9'sd1 : 9'($urandom_range(0, j - 1));
        endcase
        t.last = lst;
        return t;
    endfunction

    // Called at a falling edge; returns at a falling edge after the request is taken.
    task automatic offer(joint_req_t t);
        s_valid        <= 1'b1;
        s_pos_x        <= t.pos[0];
        s_pos_y        <= t.pos[1];
        s_pos_z        <= t.pos[2];
        s_quat_w       <= t.quat[0];
        s_quat_x       <= t.quat[1];
        s_quat_y       <= t.quat[2];
        s_quat_z       <= t.quat[3];
        s_scale_x      <= t.scale[0];
        s_scale_y      <= t.scale[1];
        s_scale_z      <= t.scale[2];
        s_parent_index <= t.parent;
        s_last_joint   <= t.last;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(t);
        @(negedge aclk);
    endtask

    int burst_left = 0;

    task automatic send(joint_req_t t);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 150);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        offer(t);
        burst_left--;
    endtask

    initial begin
        int plen;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send(make_joint(32'sh7fffffff, 16'sd16384, 16'sd0, 32'sd65536, -9'sd1, 1'b0));
        send(make_joint(32'sh80000000, 16'sd11585, 16'sd11585, 32'sh7fffffff, 9'sd0, 1'b0));
        send(make_joint(32'sd65536, 16'sh7fff, 16'sh7fff, 32'sh80000000, 9'sd1, 1'b0));
        send(make_joint(32'sd0, 16'sh8000, 16'sh8000, 32'sh7fffffff, 9'sd2, 1'b0));
        send(make_joint(32'sh7fffffff, 16'sh7fff, 16'sh8000, 32'sh7fffffff, 9'sd3, 1'b0));
        send(make_joint(-32'sd1, 16'sd0, 16'sd0, 32'sd0, 9'sd200, 1'b0));
        send(make_joint(32'sd12345, 16'sd16384, 16'sd0, 32'sd65536, 9'sd6, 1'b0));
        send(make_joint(32'sd777, 16'sd20000, 16'sd3000, -32'sd65536, -9'sd256, 1'b0));
        send(make_joint(32'sh40000000, 16'sd100, 16'sh8000, 32'sd131072, 9'sd255, 1'b0));
        send(make_joint(32'sh80000000, 16'sh7fff, 16'sd0, 32'sh80000000, 9'sd4, 1'b1));
        send(make_joint(32'sd1, 16'sd16384, 16'sd0, 32'sd65536, 9'sd0, 1'b0));
        send(make_joint(32'sd2, 16'sd0, 16'sd16384, 32'sd65536, 9'sd0, 1'b1));
        for (int n = 0; n < 188; n += plen) begin
            plen = $urandom_range(1, 12);
            for (int j = 0; j < plen; j++) send(rand_joint(j, j == plen - 1));
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    int rx_cycle = 0;

    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 6000 && rx_cycle < 6800) begin
            m_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 700) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        matrix_row_t got;
        if (aresetn && m_valid && m_ready) begin
            got.joint = m_joint_number;
            got.row   = m_row_number;
            got.elem  = '{m_elem_0, m_elem_1, m_elem_2, m_elem_3};
            got.fin   = m_final_row;
            sb.check_row(got);
        end
    end

    initial begin
        wait (stim_done);
        while (sb.rows_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.rows_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
